// ----- rtl/core/clt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg - command line tokenizer shared definitions
// Result kinds, operator codes, character constants and the queue entry type
// passed from the lexer front end to the output sequencer.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Result kinds
  localparam logic [1:0] KindChar    = 2'd0;
  localparam logic [1:0] KindTokEnd  = 2'd1;
  localparam logic [1:0] KindCmdEnd  = 2'd2;
  localparam logic [1:0] KindUnterm  = 2'd3;

  // Operator codes carried on a command end
  localparam logic [1:0] OpNone      = 2'd0;
  localparam logic [1:0] OpAndAnd    = 2'd1;
  localparam logic [1:0] OpAppend    = 2'd2;

  // Characters with a meaning to the lexer
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChAmp       = 8'h26;
  localparam logic [7:0] ChGreater   = 8'h3E;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;

  // Largest number of results one input beat can cause
  localparam int unsigned MaxResults = 4;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [1:0] op;
  } result_t;

  // All results of one input beat
  typedef struct packed {
    logic [2:0]                cnt;
    result_t [MaxResults-1:0]  res;
  } entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic result_t mk_result(logic [1:0] kind, logic [7:0] ch, logic [1:0] op);
    result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.op   = op;
    return r;
  endfunction

endpackage

// ----- rtl/core/clt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_front - lexer front end
// Takes one character beat per cycle while the queue is not full, runs the
// lexer state and forms the whole run of results for that beat as one queue entry.
// ----------------------------------------------------------------------------
module clt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_char_i,
  input  logic              in_eol_i,
  input  clt_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output clt_pkg::entry_t   push_entry_o
);

  // Lexer modes
  localparam logic [2:0] ModeBetween = 3'd0;
  localparam logic [2:0] ModeWord    = 3'd1;
  localparam logic [2:0] ModeQuoted  = 3'd2;
  localparam logic [2:0] ModeOp1     = 3'd3;
  localparam logic [2:0] ModeOp2     = 3'd4;

  logic [2:0] mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       esc_q, esc_d;

  logic                                   accept;
  logic [2:0]                             cnt;
  clt_pkg::result_t [clt_pkg::MaxResults-1:0] res;
  logic                                   word_step;
  logic                                   is_quote;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign is_quote   = (in_char_i == clt_pkg::ChDquote) || (in_char_i == clt_pkg::ChSquote);

  // Next lexer state and result run for the current beat
  always_comb begin
    res       = '0;
    cnt       = 3'd0;
    word_step = 1'b0;
    mode_d    = mode_q;
    held_d    = held_q;
    esc_d     = esc_q;
    if (in_eol_i) begin
      // close whatever is open, then always end the command
      unique case (mode_q)
        ModeWord: begin
          res[0] = clt_pkg::mk_result(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
          cnt    = 3'd1;
        end
        ModeQuoted: begin
          res[0] = clt_pkg::mk_result(clt_pkg::KindUnterm, 8'h00, clt_pkg::OpNone);
          cnt    = 3'd1;
        end
        ModeOp1: begin
          res[0] = clt_pkg::mk_result(clt_pkg::KindChar, held_q, clt_pkg::OpNone);
          res[1] = clt_pkg::mk_result(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
          cnt    = 3'd2;
        end
        ModeOp2: begin
          res[0] = clt_pkg::mk_result(clt_pkg::KindChar, held_q, clt_pkg::OpNone);
          res[1] = clt_pkg::mk_result(clt_pkg::KindChar, held_q, clt_pkg::OpNone);
          res[2] = clt_pkg::mk_result(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
          cnt    = 3'd3;
        end
        default: begin
        end
      endcase
      res[cnt[1:0]] = clt_pkg::mk_result(clt_pkg::KindCmdEnd, 8'h00, clt_pkg::OpNone);
      cnt           = cnt + 3'd1;
      mode_d        = ModeBetween;
      held_d        = 8'h00;
      esc_d         = 1'b0;
    end else begin
      unique case (mode_q)
        ModeWord: begin
          word_step = 1'b1;
        end
        ModeQuoted: begin
          if (is_quote && !esc_q) begin
            res[0] = clt_pkg::mk_result(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
            cnt    = 3'd1;
            mode_d = ModeBetween;
            esc_d  = 1'b0;
          end else if (in_char_i == clt_pkg::ChBackslash) begin
            esc_d = 1'b1;
          end else begin
            res[0] = clt_pkg::mk_result(clt_pkg::KindChar, in_char_i, clt_pkg::OpNone);
            cnt    = 3'd1;
            esc_d  = 1'b0;
          end
        end
        ModeOp1: begin
          if (in_char_i == held_q) begin
            mode_d = ModeOp2;
          end else begin
            // operator not confirmed: held byte becomes word content
            res[0]    = clt_pkg::mk_result(clt_pkg::KindChar, held_q, clt_pkg::OpNone);
            cnt       = 3'd1;
            word_step = 1'b1;
          end
        end
        ModeOp2: begin
          if (in_char_i == clt_pkg::ChSpace) begin
            res[0] = clt_pkg::mk_result(clt_pkg::KindCmdEnd, 8'h00,
                                        (held_q == clt_pkg::ChAmp) ? clt_pkg::OpAndAnd
                                                                   : clt_pkg::OpAppend);
            cnt    = 3'd1;
            mode_d = ModeBetween;
            held_d = 8'h00;
          end else begin
            res[0]    = clt_pkg::mk_result(clt_pkg::KindChar, held_q, clt_pkg::OpNone);
            res[1]    = clt_pkg::mk_result(clt_pkg::KindChar, held_q, clt_pkg::OpNone);
            cnt       = 3'd2;
            word_step = 1'b1;
          end
        end
        default: begin
          // between tokens; unused codes behave the same
          mode_d = ModeBetween;
          if (in_char_i == clt_pkg::ChSpace) begin
          end else if (is_quote) begin
            mode_d = ModeQuoted;
            esc_d  = 1'b0;
          end else if ((in_char_i == clt_pkg::ChAmp) || (in_char_i == clt_pkg::ChGreater)) begin
            held_d = in_char_i;
            mode_d = ModeOp1;
          end else begin
            word_step = 1'b1;
          end
        end
      endcase
      // plain word character handling
      if (word_step) begin
        if (in_char_i == clt_pkg::ChSpace) begin
          res[cnt[1:0]] = clt_pkg::mk_result(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
          cnt           = cnt + 3'd1;
          mode_d        = ModeBetween;
        end else begin
          if (in_char_i != clt_pkg::ChBackslash) begin
            res[cnt[1:0]] = clt_pkg::mk_result(clt_pkg::KindChar, in_char_i, clt_pkg::OpNone);
            cnt           = cnt + 3'd1;
          end
          mode_d = ModeWord;
        end
      end
    end
  end

  // Push only beats that cause results
  assign push_o           = accept && (cnt != 3'd0);
  assign push_entry_o.cnt = cnt;
  assign push_entry_o.res = res;

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeBetween;
      held_q <= 8'h00;
      esc_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      esc_q  <= esc_d;
    end
  end

endmodule

// ----- rtl/core/clt_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_queue - result run queue
// Small register queue of result runs between the lexer and the output
// sequencer. Depth of two or more.
// ----------------------------------------------------------------------------
module clt_queue #(
  parameter int unsigned Depth = clt_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  clt_pkg::entry_t   push_entry_i,
  input  logic              pop_i,
  output clt_pkg::entry_t   head_o,
  output clt_pkg::q_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  clt_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- rtl/core/clt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_back - output sequencer
// Walks the results of the queue head entry, one output beat per result,
// and marks the final result of each run.
// ----------------------------------------------------------------------------
module clt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clt_pkg::entry_t   head_i,
  input  clt_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output clt_pkg::result_t  out_res_o,
  output logic              out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       beat;

  assign out_valid_o = !q_stat_i.empty;
  assign out_res_o   = head_i.res[idx_q];
  assign out_last_o  = ({1'b0, idx_q} == (head_i.cnt - 3'd1));
  assign beat        = out_valid_o && out_ready_i;
  assign pop_o       = beat && out_last_o;

  // Result index within the head entry
  always_comb begin
    idx_d = idx_q;
    if (beat) begin
      idx_d = out_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ----- rtl/core/command_line_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer - streaming command line tokenizer
// Splits a command line, one byte per beat, into token characters, token
// ends, command ends with their operator, and unterminated quote flags.
// ----------------------------------------------------------------------------
// The input side takes one byte per cycle whenever the result queue has a free
// entry; the lexer decides all results of a byte in that same cycle and writes
// them to the queue as one entry, so a byte that gives no result (a space
// between tokens, a quote or operator opening) writes no entry at all.
// The output side sends one result per cycle while the receiver is ready;
// the results of a byte (0 to 4) are sent one after another from the queue
// entry that holds them. Sustained input rate is one byte per cycle as
// long as the results average at most one per byte; otherwise the output port
// sets the pace and the queue of QueueDepth entries absorbs bursts.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
  parameter int unsigned QueueDepth = clt_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // end_of_line
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_char, [9:8] operator_code, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast    // last_of_run
);

  logic              push;
  clt_pkg::entry_t   push_entry;
  logic              pop;
  clt_pkg::entry_t   head;
  clt_pkg::q_stat_t  q_stat;
  clt_pkg::result_t  out_res;

  // Lexer front end
  clt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata),
    .in_eol_i     (s_axis_tlast),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Result run queue
  clt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  // Output sequencer
  clt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_res.op, out_res.ch};
  assign m_axis_tuser = out_res.kind;

endmodule

// ----- rtl/core/clt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_checker - tokenizer port checks
// Concurrent checks on the result stream of the tokenizer, bound to the top.
// ----------------------------------------------------------------------------
module clt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled beat holds its contents
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // A command end always closes its run
  a_cmd_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == clt_pkg::KindCmdEnd) |-> m_axis_tlast)
    else $error("command end not last of run");

  // An unterminated quote is always followed by a command end
  a_unterm_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == clt_pkg::KindUnterm) |-> !m_axis_tlast)
    else $error("unterminated quote ends a run");

  // Only token characters carry a character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != clt_pkg::KindChar) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("non-character beat carries a character");

  // Operators appear only on command ends, with a legal code
  a_op_cmd_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[9:8] != clt_pkg::OpNone) |->
      (m_axis_tuser == clt_pkg::KindCmdEnd) &&
      ((m_axis_tdata[9:8] == clt_pkg::OpAndAnd) || (m_axis_tdata[9:8] == clt_pkg::OpAppend)))
    else $error("operator code on wrong beat");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/command_line_tokenizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_tb - self-checking bench for the command line tokenizer
// Streams command line bytes into the block and predicts every token char,
// token end, command end and unterminated-quote result with a lexer model of
// its own. Results are checked in order against that prediction. A directed
// part covers the lexing rules; random lines follow under several phases of
// sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned RandomBeats  = 75;

  // Lexer modes of the prediction
  typedef enum logic [2:0] {
    LexBetween = 3'd0,
    LexWord    = 3'd1,
    LexQuoted  = 3'd2,
    LexHeld1   = 3'd3,
    LexHeld2   = 3'd4
  } lex_mode_e;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [1:0] op;
    logic       last;
  } tok_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_char
  logic        s_axis_tlast = 1'b0;    // end_of_line
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_char, [9:8] operator_code
  logic [1:0]  m_axis_tuser;           // [1:0] out_kind
  logic        m_axis_tlast;           // last_of_run

  // Predicted lexer state
  lex_mode_e   lex_mode;
  logic [7:0]  held_chars [2];
  logic [1:0]  held_count;
  logic        esc_pending;

  tok_result_t expected_results [$];
  int unsigned step_results;
  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  command_line_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Lexer prediction
  // ---------------------------------------------------------------------------
  function automatic logic is_quote_char(input logic [7:0] c);
    return (c == clt_pkg::ChDquote) || (c == clt_pkg::ChSquote);
  endfunction

  task automatic tok_emit(input logic [1:0] kind, input logic [7:0] ch,
                          input logic [1:0] op);
    tok_result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.op   = op;
    r.last = 1'b0;
    expected_results.push_back(r);
    step_results++;
  endtask

  task automatic lex_clear;
    lex_mode      = LexBetween;
    held_chars[0] = 8'h00;
    held_chars[1] = 8'h00;
    held_count    = 2'd0;
    esc_pending   = 1'b0;
  endtask

  // Unquoted word content; a space closes the word, backslashes vanish
  task automatic tok_word_byte(input logic [7:0] c);
    if (c == clt_pkg::ChSpace) begin
      tok_emit(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
      lex_mode = LexBetween;
    end else begin
      if (c != clt_pkg::ChBackslash) tok_emit(clt_pkg::KindChar, c, clt_pkg::OpNone);
      lex_mode = LexWord;
    end
  endtask

  task automatic tok_flush_held;
    for (int i = 0; i < held_count; i++) begin
      tok_emit(clt_pkg::KindChar, held_chars[i], clt_pkg::OpNone);
    end
    held_count    = 2'd0;
    held_chars[0] = 8'h00;
    held_chars[1] = 8'h00;
  endtask

  // Works out all results of one accepted byte
  task automatic tokenize_beat(input logic [7:0] c, input logic eol);
    step_results = 0;
    if (eol) begin
      case (lex_mode)
        LexWord:   tok_emit(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
        LexQuoted: tok_emit(clt_pkg::KindUnterm, 8'h00, clt_pkg::OpNone);
        LexHeld1, LexHeld2: begin
          tok_flush_held();
          tok_emit(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
        end
        default: ;
      endcase
      tok_emit(clt_pkg::KindCmdEnd, 8'h00, clt_pkg::OpNone);
      lex_clear();
    end else begin
      case (lex_mode)
        LexWord: tok_word_byte(c);
        LexQuoted: begin
          if (is_quote_char(c) && !esc_pending) begin
            tok_emit(clt_pkg::KindTokEnd, 8'h00, clt_pkg::OpNone);
            lex_mode    = LexBetween;
            esc_pending = 1'b0;
          end else if (c == clt_pkg::ChBackslash) begin
            esc_pending = 1'b1;
          end else begin
            tok_emit(clt_pkg::KindChar, c, clt_pkg::OpNone);
            esc_pending = 1'b0;
          end
        end
        LexHeld1: begin
          if (c == held_chars[0]) begin
            held_chars[1] = c;
            held_count    = 2'd2;
            lex_mode      = LexHeld2;
          end else begin
            tok_flush_held();
            tok_word_byte(c);
          end
        end
        LexHeld2: begin
          if (c == clt_pkg::ChSpace) begin
            tok_emit(clt_pkg::KindCmdEnd, 8'h00,
                     (held_chars[0] == clt_pkg::ChAmp) ? clt_pkg::OpAndAnd
                                                       : clt_pkg::OpAppend);
            held_count    = 2'd0;
            held_chars[0] = 8'h00;
            held_chars[1] = 8'h00;
            lex_mode      = LexBetween;
          end else begin
            tok_flush_held();
            tok_word_byte(c);
          end
        end
        default: begin
          lex_mode = LexBetween;
          if (c == clt_pkg::ChSpace) begin
            // gap between tokens
          end else if (is_quote_char(c)) begin
            lex_mode    = LexQuoted;
            esc_pending = 1'b0;
          end else if (c == clt_pkg::ChAmp || c == clt_pkg::ChGreater) begin
            held_chars[0] = c;
            held_count    = 2'd1;
            lex_mode      = LexHeld1;
          end else begin
            tok_word_byte(c);
          end
        end
      endcase
    end
    if (step_results > 0) expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    tok_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat kind %0d char %02h op %0d last %0b", $time,
                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8], m_axis_tlast);
      end else begin
        want = expected_results.pop_front();
        if ({m_axis_tuser, m_axis_tdata, m_axis_tlast} !==
            {want.kind, 6'b0, want.op, want.ch, want.last}) begin
          error_count++;
          $display("%0t: mismatch expected kind %0d char %02h op %0d last %0b pad 00",
                   $time, want.kind, want.ch, want.op, want.last);
          $display("%0t:          actual   kind %0d char %02h op %0d last %0b pad %02h",
                   $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
                   m_axis_tlast, m_axis_tdata[15:10]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] c, input logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tokenize_beat(c, eol);
    beats_sent++;
  endtask

  task automatic send_eol;
    send_beat(8'($urandom), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_word_char;
    case ($urandom_range(0, 9))
      6:       return clt_pkg::ChBackslash;
      7:       return $urandom_range(0, 1) ? clt_pkg::ChDquote : clt_pkg::ChSquote;
      8:       return $urandom_range(0, 1) ? clt_pkg::ChAmp : clt_pkg::ChGreater;
      9:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  // One random piece of a command line, mostly well formed
  task automatic send_fragment;
    int unsigned n;
    logic [7:0]  q;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        for (int i = 0; i < n; i++) send_beat(rand_word_char(), 1'b0);
        send_beat(clt_pkg::ChSpace, 1'b0);
      end
      3, 4: begin
        q = $urandom_range(0, 1) ? clt_pkg::ChDquote : clt_pkg::ChSquote;
        send_beat(q, 1'b0);
        for (int i = 0; i < n - 1; i++) begin
          case ($urandom_range(0, 5))
            0: begin
              send_beat(clt_pkg::ChBackslash, 1'b0);
              send_beat($urandom_range(0, 1) ? clt_pkg::ChDquote : clt_pkg::ChSquote, 1'b0);
            end
            1:       send_beat(clt_pkg::ChBackslash, 1'b0);
            2:       send_beat(clt_pkg::ChSpace, 1'b0);
            default: send_beat(rand_word_char(), 1'b0);
          endcase
        end
        if ($urandom_range(0, 9) != 0)
          send_beat($urandom_range(0, 1) ? clt_pkg::ChDquote : clt_pkg::ChSquote, 1'b0);
      end
      5, 6: begin
        q = $urandom_range(0, 1) ? clt_pkg::ChAmp : clt_pkg::ChGreater;
        send_beat(q, 1'b0);
        send_beat(($urandom_range(0, 4) != 0) ? q : rand_word_char(), 1'b0);
        send_beat(($urandom_range(0, 4) != 0) ? clt_pkg::ChSpace : rand_word_char(), 1'b0);
      end
      7: begin
        send_beat($urandom_range(0, 1) ? clt_pkg::ChAmp : clt_pkg::ChGreater, 1'b0);
        send_beat(rand_word_char(), 1'b0);
      end
      8:  for (int i = 0; i < n % 3 + 1; i++) send_beat(clt_pkg::ChSpace, 1'b0);
      9:  send_beat(8'($urandom_range(0, 255)), 1'b0);
      10: send_eol();
      default: begin
        for (int i = 0; i < n; i++) send_beat(rand_word_char(), 1'b0);
        send_eol();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // A gap space, dropped backslash, quote inside a word, byte zero, line end in a word
  task automatic test_word_rules;
    send_text(" x\\\"");
    send_beat(8'h00, 1'b0);
    send_eol();
  endtask

  // Empty quoted token, escaped quote, mixed quote kinds, unterminated quote
  task automatic test_quote_rules;
    send_text("\"\"'a\\\"\"");
    send_text("\"");
    send_eol();
  endtask

  // Both operators, an unconfirmed operator, held bytes at line end, empty line
  task automatic test_operator_rules;
    send_text("&& >> >&");
    send_eol();
    send_text("&&");
    send_eol();
    send_eol();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = beats_sent + RandomBeats;
    while (beats_sent < stop_at) send_fragment();
  endtask

  initial begin
    lex_clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_word_rules();
    test_quote_rules();
    test_operator_rules();
    test_random_traffic(0, 0);
    test_random_traffic(46, 0);
    test_random_traffic(0, 46);
    test_random_traffic(13, 13);

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
